@@ rtl/accel_shake_detector_top_defines.svh @@
// assertion macros for the shake detector checker
`ifndef ACCEL_SHAKE_DETECTOR_TOP_DEFINES_SVH
`define ACCEL_SHAKE_DETECTOR_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define ASD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("shake detector check failed");

// condition in one cycle implies a condition in the next
`define ASD_ASSERT_NEXT(label, cond, nxt) \
	`ASD_ASSERT(label, (cond) |=> (nxt))

`endif

@@ rtl/asd_pkg.sv @@
// shared types, constants and helpers of the shake detector
`default_nettype none

package asd_pkg;

	localparam int TIME_W     = 32;
	localparam int NOW_W      = 32;
	localparam int ACCEL_W    = 16;
	localparam int SQ_W       = 2 * ACCEL_W - 1;
	localparam int MAG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COUNT_W    = 8;

	localparam logic [COUNT_W-1:0] HIT_MAX = '1;

	localparam logic [31:0] RST_THRESHOLD_SQ  = 32'd67108864;
	localparam logic [15:0] RST_COOLDOWN_MS   = 16'd800;
	localparam logic [15:0] RST_WINDOW_MS     = 16'd500;
	localparam logic [15:0] RST_MIN_SPAN_MS   = 16'd120;
	localparam logic [7:0]  RST_HITS_REQUIRED = 8'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_SQ  = 3'd0,
		REG_COOLDOWN_MS   = 3'd1,
		REG_WINDOW_MS     = 3'd2,
		REG_MIN_SPAN_MS   = 3'd3,
		REG_HITS_REQUIRED = 3'd4
	} cfg_reg_t;

	typedef logic [TIME_W-1:0] time_t;

	typedef struct packed {
		logic [31:0] threshold_sq;
		logic [15:0] cooldown_ms;
		logic [15:0] window_ms;
		logic [15:0] min_span_ms;
		logic [7:0]  hits_required;
	} cfg_t;

	typedef struct packed {
		logic            valid;
		logic [SQ_W-1:0] sq_x;
		logic [SQ_W-1:0] sq_y;
		logic [SQ_W-1:0] sq_z;
		time_t           now;
	} mag_beat_t;

	// timestamp reduced or zero-extended to the internal time width
	function automatic time_t to_time(input logic [NOW_W-1:0] v);
		logic [63:0] w;
		w = {{(64-NOW_W){1'b0}}, v};
		return w[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/asd_cfg_regs.sv @@
// configuration registers of the shake detector
`default_nettype none

module asd_cfg_regs
	import asd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_sq  <= RST_THRESHOLD_SQ;
			cfg_q.cooldown_ms   <= RST_COOLDOWN_MS;
			cfg_q.window_ms     <= RST_WINDOW_MS;
			cfg_q.min_span_ms   <= RST_MIN_SPAN_MS;
			cfg_q.hits_required <= RST_HITS_REQUIRED;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD_SQ:  cfg_q.threshold_sq  <= cfg_data[31:0];
				REG_COOLDOWN_MS:   cfg_q.cooldown_ms   <= cfg_data[15:0];
				REG_WINDOW_MS:     cfg_q.window_ms     <= cfg_data[15:0];
				REG_MIN_SPAN_MS:   cfg_q.min_span_ms   <= cfg_data[15:0];
				REG_HITS_REQUIRED: cfg_q.hits_required <= cfg_data[7:0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/asd_mag.sv @@
// input register and per-axis squaring stage
`default_nettype none

module asd_mag
	import asd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [ACCEL_W-1:0] accel_x,
	input  wire logic [ACCEL_W-1:0] accel_y,
	input  wire logic [ACCEL_W-1:0] accel_z,
	input  wire logic [NOW_W-1:0]   now_ms,
	input  wire logic               take,
	output mag_beat_t               beat
);

	logic                      valid_s1, valid_s2;
	logic signed [ACCEL_W-1:0] x_s1, y_s1, z_s1;
	time_t                     now_s1, now_s2;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2, sqz_s2;
	logic signed [2*ACCEL_W-1:0] px, py, pz;
	logic                      adv_s1, adv_s2;

	// each stage moves when empty or when the one after it moves
	assign adv_s2   = !valid_s2 || take;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign px = x_s1 * x_s1;
	assign py = y_s1 * y_s1;
	assign pz = z_s1 * z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			x_s1   <= accel_x;
			y_s1   <= accel_y;
			z_s1   <= accel_z;
			now_s1 <= to_time(now_ms);
		end
		if (adv_s2 && valid_s1) begin
			// a square of a 16-bit value is nonnegative and fits 31 bits
			sqx_s2 <= px[SQ_W-1:0];
			sqy_s2 <= py[SQ_W-1:0];
			sqz_s2 <= pz[SQ_W-1:0];
			now_s2 <= now_s1;
		end
	end

	assign beat.valid = valid_s2;
	assign beat.sq_x  = sqx_s2;
	assign beat.sq_y  = sqy_s2;
	assign beat.sq_z  = sqz_s2;
	assign beat.now   = now_s2;

endmodule

`default_nettype wire

@@ rtl/asd_detect.sv @@
// window, cooldown and peak tracking with the result register
`default_nettype none

module asd_detect
	import asd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire mag_beat_t        beat,
	output logic                  take,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  shake,
	output logic [MAG_W-1:0]      peak_sq
);

	time_t              last_q, start_q;
	logic [COUNT_W-1:0] count_q;
	logic [MAG_W-1:0]   peak_q;

	logic               out_valid_q, shake_q;
	logic [MAG_W-1:0]   peak_out_q;

	logic [MAG_W-1:0]   mag;
	time_t              since_last, since_start, span;
	logic               fire, cool, hit, restart, expired, confirm;
	logic [COUNT_W-1:0] next_count;
	logic [MAG_W-1:0]   next_peak;

	assign take = !out_valid_q || !out_stall;
	assign fire = beat.valid && take;

	always_comb begin
		mag = MAG_W'(beat.sq_x) + MAG_W'(beat.sq_y) + MAG_W'(beat.sq_z);
		since_last  = beat.now - last_q;
		since_start = beat.now - start_q;
		cool    = since_last < TIME_W'(cfg.cooldown_ms);
		hit     = mag > cfg.threshold_sq;
		expired = since_start > TIME_W'(cfg.window_ms);
		restart = (count_q == '0) || expired;
		if (restart) begin
			next_count = COUNT_W'(1);
			next_peak  = mag;
			span       = '0;
		end else begin
			next_count = (count_q < HIT_MAX) ? count_q + COUNT_W'(1) : count_q;
			next_peak  = (mag > peak_q) ? mag : peak_q;
			span       = since_start;
		end
		confirm = !cool && hit && (next_count >= cfg.hits_required)
			&& (span >= TIME_W'(cfg.min_span_ms));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			start_q     <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) out_valid_q <= beat.valid;
			if (fire && !cool) begin
				if (hit) begin
					if (restart) start_q <= beat.now;
					peak_q  <= next_peak;
					count_q <= confirm ? '0 : next_count;
					if (confirm) last_q <= beat.now;
				end else if (count_q != '0 && expired) begin
					count_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			shake_q    <= confirm;
			peak_out_q <= confirm ? next_peak : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign shake     = shake_q;
	assign peak_sq   = peak_out_q;

endmodule

`default_nettype wire

@@ rtl/accel_shake_detector_top.sv @@
// top level of the accelerometer shake detector
// The block takes one sample beat (signed x, y, z and a millisecond timestamp) per clock
// while in_stall is low and returns exactly one result beat for it: shake and the peak squared
// magnitude of the confirmed window (zero when no shake). A beat passes an input register, a
// squaring stage and the result register. A new sample can be taken every cycle while the
// result beat is not stalled, because the window, cooldown and peak state is updated in the
// single cycle in which a beat enters the result register. Input stall rises only while the
// pipeline is full and the result beat is stalled. Configuration writes take effect on the
// next edge and are meant to happen with the pipeline empty.
`default_nettype none

module accel_shake_detector_top
	import asd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [ACCEL_W-1:0]    accel_x,
	input  wire logic [ACCEL_W-1:0]    accel_y,
	input  wire logic [ACCEL_W-1:0]    accel_z,
	input  wire logic [NOW_W-1:0]      now_ms,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       shake,
	output logic [MAG_W-1:0]           peak_sq
);

	cfg_t      cfg;
	mag_beat_t beat;
	logic      take;

	asd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	asd_mag u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.now_ms   (now_ms),
		.take     (take),
		.beat     (beat)
	);

	asd_detect u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.beat      (beat),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.shake     (shake),
		.peak_sq   (peak_sq)
	);

endmodule

`default_nettype wire

@@ rtl/asd_checker.sv @@
// port-level checks of the shake detector and their binding
`default_nettype none
`include "accel_shake_detector_top_defines.svh"

module asd_checker
	import asd_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic                  shake,
	input wire logic [MAG_W-1:0]      peak_sq
);

	// a stalled result beat holds
	`ASD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(shake) && $stable(peak_sq))
	// peak is reported only with a shake
	`ASD_ASSERT(a_peak_zero, (out_valid && !shake) |-> (peak_sq == '0))
	// a confirmed window always has a nonzero peak
	`ASD_ASSERT(a_peak_set, (out_valid && shake) |-> (peak_sq != '0))
	// input backpressure only comes from a stalled result beat
	`ASD_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall))

endmodule

bind accel_shake_detector_top asd_checker u_chk (.*);

`default_nettype wire
